### rtl/sed_pkg.sv
`timescale 1ns / 1ps

package sed_pkg;

  // Default sizes of the store and of the read-out preamble.
  localparam int unsigned BlocksDef  = 1024;
  localparam int unsigned ReadPadDef = 4;

  // Fixed widths of the serial protocol.
  localparam int unsigned AddrWLong  = 14;
  localparam int unsigned AddrWShort = 6;
  localparam int unsigned DataW      = 64;
  localparam int unsigned CntW       = 7;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_KIND,
    PH_ADDR,
    PH_DATA,
    PH_STOP,
    PH_OUT
  } phase_e;

  // Request from the protocol engine to the block store.
  typedef struct packed {
    logic                 wr_en;
    logic                 rd_en;
    logic [AddrWLong-1:0] addr;
    logic [DataW-1:0]     wdata;
  } store_req_t;

endpackage

### rtl/sed_store.sv
`timescale 1ns / 1ps

module sed_store
  import sed_pkg::*;
#(
  parameter int unsigned BLOCKS = BlocksDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  store_req_t       req_i,
  output logic [DataW-1:0] rdata_o,
  output logic             busy_o
);

  localparam int unsigned AW = $clog2(BLOCKS);

  logic [DataW-1:0] mem [BLOCKS];
  logic [DataW-1:0] rdata_q;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic             busy_q, busy_d;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [DataW-1:0] wdata;

  // The erase sweep owns the write port until every block holds all ones.
  always_comb begin
    clr_addr_d = clr_addr_q;
    busy_d     = busy_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(BLOCKS - 1)) begin
        busy_d = 1'b0;
      end
    end
    we    = busy_q | req_i.wr_en;
    waddr = busy_q ? clr_addr_q : req_i.addr[AW-1:0];
    wdata = busy_q ? '1 : req_i.wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

### rtl/sed_ctrl.sv
`timescale 1ns / 1ps

module sed_ctrl
  import sed_pkg::*;
#(
  parameter int unsigned READ_PAD_BITS = ReadPadDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             cmd_i,
  input  logic             write_bit_i,
  input  logic             long_address_i,
  input  logic [DataW-1:0] rdata_i,
  output logic             read_bit_o,
  output store_req_t       store_req_o
);

  localparam logic [CntW-1:0] PadLen = CntW'(READ_PAD_BITS);
  localparam logic [CntW-1:0] OutLen = CntW'(READ_PAD_BITS + DataW);
  localparam logic [CntW-1:0] DatLen = CntW'(DataW);

  phase_e               phase_q, phase_d;
  logic [CntW-1:0]      cnt_q, cnt_d, cnt_inc;
  logic                 is_read_q, is_read_d;
  logic [AddrWLong-1:0] addr_q, addr_d;
  logic [DataW-1:0]     data_q, data_d, data_eff;
  logic                 rd_load_q, rd_load_d;
  logic [CntW-1:0]      addr_len;

  // Block data fetched at the stop bit lands in the cycle after it.
  assign data_eff = rd_load_q ? rdata_i : data_q;
  assign cnt_inc  = cnt_q + CntW'(1);
  assign addr_len = long_address_i ? CntW'(AddrWLong) : CntW'(AddrWShort);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    is_read_d   = is_read_q;
    addr_d      = addr_q;
    data_d      = data_eff;
    rd_load_d   = 1'b0;
    read_bit_o  = 1'b0;
    store_req_o = '{wr_en: 1'b0, rd_en: 1'b0, addr: addr_q, wdata: data_eff};

    if (accept_i && cmd_i) begin
      case (phase_q)
        PH_KIND: begin
          is_read_d = write_bit_i;
          addr_d    = '0;
          cnt_d     = '0;
          phase_d   = PH_ADDR;
        end
        PH_ADDR: begin
          addr_d = {addr_q[AddrWLong-2:0], write_bit_i};
          cnt_d  = cnt_inc;
          if (cnt_inc >= addr_len) begin
            cnt_d   = '0;
            phase_d = is_read_q ? PH_STOP : PH_DATA;
          end
        end
        PH_DATA: begin
          data_d = {data_eff[DataW-2:0], write_bit_i};
          cnt_d  = cnt_inc;
          if (cnt_inc >= DatLen) begin
            cnt_d   = '0;
            phase_d = PH_STOP;
          end
        end
        PH_STOP: begin
          cnt_d = '0;
          if (is_read_q) begin
            store_req_o.rd_en = 1'b1;
            rd_load_d         = 1'b1;
            phase_d           = PH_OUT;
          end else begin
            store_req_o.wr_en = 1'b1;
            phase_d           = PH_IDLE;
          end
        end
        default: begin
          // Idle, or a read-out abandoned by a new request.
          cnt_d   = '0;
          phase_d = write_bit_i ? PH_KIND : PH_IDLE;
        end
      endcase
    end else if (accept_i) begin
      if (phase_q != PH_OUT) begin
        read_bit_o = 1'b1;
      end else begin
        if (cnt_q < PadLen) begin
          read_bit_o = 1'b0;
        end else begin
          read_bit_o = data_eff[DataW-1];
          data_d     = {data_eff[DataW-2:0], 1'b0};
        end
        cnt_d = cnt_inc;
        if (cnt_inc >= OutLen) begin
          cnt_d   = '0;
          phase_d = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cnt_q     <= '0;
      is_read_q <= 1'b0;
      addr_q    <= '0;
      data_q    <= '0;
      rd_load_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      is_read_q <= is_read_d;
      addr_q    <= addr_d;
      data_q    <= data_d;
      rd_load_q <= rd_load_d;
    end
  end

endmodule

### rtl/serial_eeprom_bit_device.sv
`timescale 1ns / 1ps

// Channel   | Direction | tdata (low bit up)     | tuser (low bit up)
// ----------+-----------+------------------------+--------------------------
// s_axis    | in        | write_bit, 7 zero bits | cmd (0 read, 1 write)
// m_axis    | out       | read_bit, 7 zero bits  | none
// cfg       | in        | cfg_wdata_i: long_address, written when cfg_we_i is high
//
// The protocol engine works between the held state and the result register, so
// one request is taken in every cycle unless the erase sweep or a waiting result
// stalls the input. After reset the store is erased to all ones by a sweep over
// all BLOCKS blocks, one block per cycle through the store's write port; no
// request is taken during the sweep, while configuration writes are.
// A result waiting in the output register stalls the input only if the
// downstream side is not taking it in the same cycle.

module serial_eeprom_bit_device
  import sed_pkg::*;
#(
  parameter int unsigned BLOCKS        = BlocksDef,
  parameter int unsigned READ_PAD_BITS = ReadPadDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Request stream.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] write_bit, [7:1] zero
  input  logic [0:0] s_axis_tuser,   // [0] cmd
  // Result stream.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] read_bit, [7:1] zero
  // Configuration.
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i     // long_address
);

  logic             accept;
  logic             long_q;
  logic             busy;
  logic             read_bit;
  logic [DataW-1:0] rdata;
  store_req_t       store_req;
  logic             m_valid_q, m_valid_d;
  logic             m_bit_q, m_bit_d;

  // The result register frees up in the same cycle as downstream takes it.
  assign s_axis_tready = !busy && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q <= 1'b0;
    end else if (cfg_we_i) begin
      long_q <= cfg_wdata_i;
    end
  end

  sed_ctrl #(
    .READ_PAD_BITS(READ_PAD_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .cmd_i         (s_axis_tuser[0]),
    .write_bit_i   (s_axis_tdata[0]),
    .long_address_i(long_q),
    .rdata_i       (rdata),
    .read_bit_o    (read_bit),
    .store_req_o   (store_req)
  );

  sed_store #(
    .BLOCKS(BLOCKS)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .rdata_o(rdata),
    .busy_o (busy)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    m_bit_d   = m_bit_q;
    if (accept) begin
      m_valid_d = 1'b1;
      m_bit_d   = read_bit;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_bit_q <= m_bit_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_bit_q};

  // No request may reach the store while the erase sweep runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready && !store_req.wr_en && !store_req.rd_en)
    else $error("request taken during erase sweep");

  // Every accepted request leaves a result behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  // A write access always answers with a zero bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser[0] |=> m_axis_tdata[0] == 1'b0)
    else $error("write access returned a non-zero bit");

  // The store is never asked to read and write in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(store_req.wr_en && store_req.rd_en))
    else $error("store read and write issued together");

endmodule
